// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the distance field block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ----- hw/rtl/wsdf_pkg.sv -----
// Shared types and constants for the window-search distance field block.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package wsdf_pkg;

    // transaction field widths
    localparam int OP_W     = 1;
    localparam int IDX_W    = 18;
    localparam int CHAN_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int OXY_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_SW_W   = 10;
    localparam int CFG_SH_W   = 10;
    localparam int CFG_OW_W   = 9;
    localparam int CFG_OH_W   = 9;
    localparam int CFG_R_W    = 7;

    localparam logic [CFG_SW_W-1:0] RST_SRC_WIDTH  = 10'd512;
    localparam logic [CFG_SH_W-1:0] RST_SRC_HEIGHT = 10'd512;
    localparam logic [CFG_OW_W-1:0] RST_OUT_WIDTH  = 9'd128;
    localparam logic [CFG_OH_W-1:0] RST_OUT_HEIGHT = 9'd128;
    localparam logic [CFG_R_W-1:0]  RST_RADIUS     = 7'd32;

    // fixed point
    localparam int V_W      = 17;
    localparam int NUM_W    = 26;
    localparam int ONE_Q16  = 65536;
    localparam int BYTE_SHIFT = 17;
    localparam logic [BYTE_W-1:0] INSIDE_LIMIT = 8'd127;
    localparam logic [BYTE_W-1:0] BYTE_MAX     = 8'd255;
    localparam logic [CHAN_W-1:0] KEPT_CHANNEL = 2'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH     = 3'd0,
        CFG_SRC_HEIGHT    = 3'd1,
        CFG_OUT_WIDTH     = 3'd2,
        CFG_OUT_HEIGHT    = 3'd3,
        CFG_SEARCH_RADIUS = 3'd4,
        CFG_SOURCE_FORMAT = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        DIV_X = 2'd0,
        DIV_Y = 2'd1,
        DIV_R = 2'd2
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_DIVX_GO,
        S_DIVX_RUN,
        S_DIVY_GO,
        S_DIVY_RUN,
        S_WIN,
        S_BASE,
        S_CRD,
        S_CWT,
        S_SCAN,
        S_DRAIN,
        S_SQ_GO,
        S_SQ_RUN,
        S_DIVR_GO,
        S_DIVR_RUN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     ram_wr;
        logic     prep;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_x;
        logic     take_y;
        logic     win;
        logic     base;
        logic     centre_rd;
        logic     centre_take;
        logic     scan_issue;
        logic     sqrt_start;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic in_op;
        logic div_busy;
        logic sqrt_busy;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/wsdf_in_if.sv -----
// Input channel: load or query transactions with valid/ready.
// Depends on wsdf_pkg for field widths.
`timescale 1ns / 1ps

interface wsdf_in_if import wsdf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] pixel_byte;
    logic [OXY_W-1:0]  out_x;
    logic [OXY_W-1:0]  out_y;

    modport source (output valid, operation, pixel_index, channel, pixel_byte, out_x, out_y,
                    input ready);
    modport sink   (input valid, operation, pixel_index, channel, pixel_byte, out_x, out_y,
                    output ready);
endinterface

// ----- hw/rtl/wsdf_out_if.sv -----
// Result channel: encoded distance byte and inside bit with valid/ready.
// Depends on wsdf_pkg for field widths.
`timescale 1ns / 1ps

interface wsdf_out_if import wsdf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] distance_byte;
    logic              is_inside;

    modport source (output valid, distance_byte, is_inside, input ready);
    modport sink   (input valid, distance_byte, is_inside, output ready);
endinterface

// ----- hw/rtl/wsdf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wsdf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/wsdf_ctrl.sv -----
// Controller state machine: sequences load, divide, window scan, root and output.
// Depends on wsdf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsdf_ctrl import wsdf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_status.in_op == OP_QUERY) ? S_PREP : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.ram_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_DIVX_GO;
            end
            S_DIVX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_X;
                n_state = S_DIVX_RUN;
            end
            S_DIVX_RUN: begin
                if (!i_status.div_busy) begin
                    o_cmd.take_x = 1'b1;
                    n_state = S_DIVY_GO;
                end
            end
            S_DIVY_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_Y;
                n_state = S_DIVY_RUN;
            end
            S_DIVY_RUN: begin
                if (!i_status.div_busy) begin
                    o_cmd.take_y = 1'b1;
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                o_cmd.win = 1'b1;
                n_state = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state = S_CRD;
            end
            S_CRD: begin
                o_cmd.centre_rd = 1'b1;
                n_state = S_CWT;
            end
            S_CWT: begin
                o_cmd.centre_take = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SQ_GO;
            end
            S_SQ_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQ_RUN;
            end
            S_SQ_RUN: begin
                if (!i_status.sqrt_busy) begin
                    n_state = S_DIVR_GO;
                end
            end
            S_DIVR_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_R;
                n_state = S_DIVR_RUN;
            end
            S_DIVR_RUN: begin
                if (!i_status.div_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == S_LOAD || r_state == S_PREP)
    `ASSERT_NXT(a_scan_ends_in_drain, i_clk, i_rst_n, r_state == S_SCAN && i_status.scan_last, r_state == S_DRAIN)
endmodule

// ----- hw/rtl/wsdf_dp.sv -----
// Datapath: config registers, inside map, shared divider, root unit, scan pipe.
// Depends on wsdf_pkg, wsdf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsdf_dp import wsdf_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_OUT_DIM    = 256,
    parameter int MAX_RADIUS     = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [IDX_W-1:0]      i_pixel_index,
    input  logic [CHAN_W-1:0]     i_channel,
    input  logic [BYTE_W-1:0]     i_pixel_byte,
    input  logic [OXY_W-1:0]      i_out_x,
    input  logic [OXY_W-1:0]      i_out_y,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [BYTE_W-1:0]     o_distance_byte,
    output logic                  o_is_inside,
    input  t_cmd                  i_cmd,
    output t_status               o_status
);
    localparam int XW    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int XCW   = $clog2(MAX_SRC_WIDTH);
    localparam int YCW   = $clog2(MAX_SRC_HEIGHT);
    localparam int OWW   = $clog2(MAX_OUT_DIM + 1);
    localparam int RDW   = $clog2(MAX_RADIUS + 1);
    localparam int DW    = 2 * RDW + 1;
    localparam int RW    = (DW + 33) / 2;
    localparam int NXW   = OXY_W + 1 + XW;
    localparam int NYW   = OXY_W + 1 + YW;
    localparam int DN0   = (NXW > NYW) ? NXW : NYW;
    localparam int DN    = (DN0 > RW) ? DN0 : RW;
    localparam int DD    = (OWW + 1 > RDW) ? OWW + 1 : RDW;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW0   = (XW > YW) ? XW : YW;
    localparam int EW    = ((EW0 > RDW) ? EW0 : RDW) + 1;
    localparam int DCW   = $clog2(DN + 1);
    localparam int SCW   = $clog2(RW + 1);

    // configuration
    logic [CFG_SW_W-1:0] r_cfg_w;
    logic [CFG_SH_W-1:0] r_cfg_h;
    logic [CFG_OW_W-1:0] r_cfg_ow;
    logic [CFG_OH_W-1:0] r_cfg_oh;
    logic [CFG_R_W-1:0]  r_cfg_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= RST_SRC_WIDTH;
            r_cfg_h  <= RST_SRC_HEIGHT;
            r_cfg_ow <= RST_OUT_WIDTH;
            r_cfg_oh <= RST_OUT_HEIGHT;
            r_cfg_r  <= RST_RADIUS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:     r_cfg_w  <= i_cfg_data[CFG_SW_W-1:0];
                CFG_SRC_HEIGHT:    r_cfg_h  <= i_cfg_data[CFG_SH_W-1:0];
                CFG_OUT_WIDTH:     r_cfg_ow <= i_cfg_data[CFG_OW_W-1:0];
                CFG_OUT_HEIGHT:    r_cfg_oh <= i_cfg_data[CFG_OH_W-1:0];
                CFG_SEARCH_RADIUS: r_cfg_r  <= i_cfg_data[CFG_R_W-1:0];
                // the format only says which bytes are channel 0; no storage needed
                CFG_SOURCE_FORMAT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // saturated working values
    logic [XW-1:0]  w_w;
    logic [YW-1:0]  w_h;
    logic [OWW-1:0] w_ow;
    logic [OWW-1:0] w_oh;
    logic [RDW-1:0] w_r;

    always_comb begin
        w_w  = (r_cfg_w == '0) ? XW'(1) :
               (int'(r_cfg_w) > MAX_SRC_WIDTH) ? XW'(MAX_SRC_WIDTH) : XW'(r_cfg_w);
        w_h  = (r_cfg_h == '0) ? YW'(1) :
               (int'(r_cfg_h) > MAX_SRC_HEIGHT) ? YW'(MAX_SRC_HEIGHT) : YW'(r_cfg_h);
        w_ow = (r_cfg_ow == '0) ? OWW'(1) :
               (int'(r_cfg_ow) > MAX_OUT_DIM) ? OWW'(MAX_OUT_DIM) : OWW'(r_cfg_ow);
        w_oh = (r_cfg_oh == '0) ? OWW'(1) :
               (int'(r_cfg_oh) > MAX_OUT_DIM) ? OWW'(MAX_OUT_DIM) : OWW'(r_cfg_oh);
        w_r  = (r_cfg_r == '0) ? RDW'(1) :
               (int'(r_cfg_r) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(r_cfg_r);
    end

    // captured transaction
    logic [IDX_W-1:0]  r_idx;
    logic [CHAN_W-1:0] r_chan;
    logic [BYTE_W-1:0] r_byte;
    logic [OXY_W-1:0]  r_ox;
    logic [OXY_W-1:0]  r_oy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx  <= i_pixel_index;
            r_chan <= i_channel;
            r_byte <= i_pixel_byte;
            r_ox   <= i_out_x;
            r_oy   <= i_out_y;
        end
    end

    // inside map
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    logic [XCW-1:0] r_sx, r_xx, r_x_lo, r_x_hi;
    logic [YCW-1:0] r_sy, r_yy, r_y_lo, r_y_hi;
    logic [AW-1:0]  r_cbase, r_rowbase;

    assign ram_we    = i_cmd.ram_wr && (r_chan == KEPT_CHANNEL) && (32'(r_idx) < 32'(DEPTH));
    assign ram_waddr = AW'(r_idx);
    assign ram_wdata = (r_byte < INSIDE_LIMIT);
    assign ram_raddr = i_cmd.centre_rd ? (r_cbase + AW'(r_sx)) : (r_rowbase + AW'(r_xx));

    wsdf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // mapping numerators
    logic [NXW-1:0] r_nx;
    logic [NYW-1:0] r_ny;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_nx <= NXW'({r_ox, 1'b1}) * NXW'(w_w);
            r_ny <= NYW'({r_oy, 1'b1}) * NYW'(w_h);
        end
    end

    // shared restoring divider, one quotient bit per cycle
    logic [DN-1:0]  r_div_q;
    logic [DD-1:0]  r_div_rem;
    logic [DD-1:0]  r_div_den;
    logic [DCW-1:0] r_div_cnt;
    logic [DN-1:0]  n_div_num;
    logic [DD-1:0]  n_div_den;
    logic [DD:0]    div_sh;
    logic           div_ge;
    logic [RW-1:0]  r_sq_root;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_X: begin
                n_div_num = DN'(r_nx);
                n_div_den = DD'({w_ow, 1'b0});
            end
            DIV_Y: begin
                n_div_num = DN'(r_ny);
                n_div_den = DD'({w_oh, 1'b0});
            end
            DIV_R: begin
                n_div_num = DN'(r_sq_root);
                n_div_den = DD'(w_r);
            end
            default: begin
                n_div_num = '0;
                n_div_den = DD'(1);
            end
        endcase
        div_sh = {r_div_rem, r_div_q[DN-1]};
        div_ge = (div_sh >= {1'b0, r_div_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= DCW'(DN);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_q   <= n_div_num;
            r_div_rem <= '0;
            r_div_den <= n_div_den;
        end else if (r_div_cnt != '0) begin
            r_div_q   <= {r_div_q[DN-2:0], div_ge};
            r_div_rem <= div_ge ? DD'(div_sh - {1'b0, r_div_den}) : DD'(div_sh);
        end
    end

    // source coordinate and clipped window
    logic [EW-1:0] ex_sx, ex_sy, ex_r, ex_w, ex_h;

    always_comb begin
        ex_sx = EW'(r_sx);
        ex_sy = EW'(r_sy);
        ex_r  = EW'(w_r);
        ex_w  = EW'(w_w);
        ex_h  = EW'(w_h);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_x) begin
            r_sx <= (r_div_q >= DN'(w_w)) ? XCW'(w_w - XW'(1)) : XCW'(r_div_q);
        end
        if (i_cmd.take_y) begin
            r_sy <= (r_div_q >= DN'(w_h)) ? YCW'(w_h - YW'(1)) : YCW'(r_div_q);
        end
        if (i_cmd.win) begin
            r_x_lo <= (ex_sx >= ex_r) ? XCW'(ex_sx - ex_r) : '0;
            r_x_hi <= (ex_sx + ex_r >= ex_w) ? XCW'(ex_w - EW'(1)) : XCW'(ex_sx + ex_r);
            r_y_lo <= (ex_sy >= ex_r) ? YCW'(ex_sy - ex_r) : '0;
            r_y_hi <= (ex_sy + ex_r >= ex_h) ? YCW'(ex_h - EW'(1)) : YCW'(ex_sy + ex_r);
        end
    end

    // offset squares
    logic [EW-1:0]    y_pick, y_abs, x_abs;
    logic [RDW-1:0]   dy, dx;
    logic [2*RDW-1:0] dy2, dx2;
    logic [2*RDW-1:0] r_dy2;
    logic [DW-1:0]    r_best;
    logic [DW-1:0]    r_s1_d;
    logic             r_s1_valid;
    logic             r_inside;
    logic             scan_last;
    logic             scan_in_win;

    always_comb begin
        y_pick = i_cmd.base ? EW'(r_y_lo) : EW'(r_yy) + EW'(1);
        y_abs  = (y_pick >= ex_sy) ? y_pick - ex_sy : ex_sy - y_pick;
        x_abs  = (EW'(r_xx) >= ex_sx) ? EW'(r_xx) - ex_sx : ex_sx - EW'(r_xx);
        dy     = RDW'(y_abs);
        dx     = RDW'(x_abs);
        dy2    = dy * dy;
        dx2    = dx * dx;
        scan_last   = (r_xx == r_x_hi) && (r_yy == r_y_hi);
        scan_in_win = (r_xx >= r_x_lo) && (r_xx <= r_x_hi) &&
                      (r_yy >= r_y_lo) && (r_yy <= r_y_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_cbase   <= AW'(r_sy * w_w);
            r_rowbase <= AW'(r_y_lo * w_w);
            r_xx      <= r_x_lo;
            r_yy      <= r_y_lo;
            r_dy2     <= dy2;
        end else if (i_cmd.scan_issue) begin
            if (r_xx == r_x_hi) begin
                r_xx      <= r_x_lo;
                r_yy      <= r_yy + YCW'(1);
                r_rowbase <= r_rowbase + AW'(w_w);
                r_dy2     <= dy2;
            end else begin
                r_xx <= r_xx + XCW'(1);
            end
        end
        if (i_cmd.scan_issue) begin
            r_s1_d <= DW'(r_dy2) + DW'(dx2);
        end
        if (i_cmd.centre_take) begin
            r_inside <= ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_best <= DW'({(2*RDW)'(w_r) * (2*RDW)'(w_r), 1'b0});
        end else if (r_s1_valid && (r_s1_d < r_best) && (ram_rdata != r_inside)) begin
            r_best <= r_s1_d;
        end
    end

    // integer square root of best * 2^32, two radicand bits per cycle
    logic [2*RW-1:0] r_sq_op;
    logic [RW+1:0]   r_sq_rem;
    logic [SCW-1:0]  r_sq_cnt;
    logic [RW+1:0]   sq_sh, sq_trial;
    logic            sq_ge;

    always_comb begin
        sq_sh    = {r_sq_rem[RW-1:0], r_sq_op[2*RW-1 -: 2]};
        sq_trial = {r_sq_root, 2'b01};
        sq_ge    = (sq_sh >= sq_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_sq_cnt <= SCW'(RW);
        end else if (r_sq_cnt != '0) begin
            r_sq_cnt <= r_sq_cnt - SCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_sq_op   <= (2*RW)'({r_best, 32'd0});
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_cnt != '0) begin
            r_sq_op   <= {r_sq_op[2*RW-3:0], 2'b00};
            r_sq_rem  <= sq_ge ? sq_sh - sq_trial : sq_sh;
            r_sq_root <= {r_sq_root[RW-2:0], sq_ge};
        end
    end

    // output encoding and result register
    logic [V_W-1:0]    v_q16;
    logic [NUM_W-1:0]  enc_num;
    logic [BYTE_W-1:0] enc_byte;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_inside;

    always_comb begin
        v_q16    = (r_div_q > DN'(ONE_Q16)) ? V_W'(ONE_Q16) : V_W'(r_div_q);
        enc_num  = r_inside ?
                   NUM_W'(BYTE_MAX) * (NUM_W'(ONE_Q16) + NUM_W'(v_q16)) :
                   NUM_W'(BYTE_MAX) * (NUM_W'(ONE_Q16) - NUM_W'(v_q16));
        enc_byte = BYTE_W'((enc_num + NUM_W'(ONE_Q16)) >> BYTE_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte   <= enc_byte;
            r_out_inside <= r_inside;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_distance_byte = r_out_byte;
    assign o_is_inside     = r_out_inside;

    always_comb begin
        o_status.in_op     = i_operation[0];
        o_status.div_busy  = (r_div_cnt != '0);
        o_status.sqrt_busy = (r_sq_cnt != '0);
        o_status.scan_last = scan_last;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    `ASSERT_NXT(a_div_runs, i_clk, i_rst_n, i_cmd.div_start, r_div_cnt != '0)
    `ASSERT_IMP(a_scan_in_window, i_clk, i_rst_n, i_cmd.scan_issue, scan_in_win)
endmodule

// ----- hw/rtl/window_search_distance_field.sv -----
// Transactions: a load writes the inside bit of one pixel; a query scans the clipped (2R+1)^2 window
//   around the mapped source pixel. Divider width DN is 24 and root width RW is 24 by default.
// Throughput: one transaction at a time; the window scan reads one map bit per cycle from
//   the single read port of the inside map, which sets the query time.
// Reset: synchronous active-low; returns the controller to idle and the config registers to
//   their defaults, and clears result valid. The inside map has no reset and must be loaded before it is queried.
`timescale 1ns / 1ps

module window_search_distance_field import wsdf_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_OUT_DIM    = 256,
    parameter int MAX_RADIUS     = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port, no read-back
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // load / query transactions in, result transactions out
    wsdf_in_if.sink               i_item,
    wsdf_out_if.source            o_result
);
    // Controller and datapath talk only through the command and status structs.
    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic    out_inside;

    // Input side is ready only in idle; a result already waiting in the output
    // register does not hold off the next transaction, only the next result load.
    assign i_item.ready = in_ready;

    wsdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath holds the config registers, inside map RAM, the shared iterative
    // divider (mapping and final scaling), the root unit and the scan pipeline.
    wsdf_dp #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_OUT_DIM    (MAX_OUT_DIM),
        .MAX_RADIUS     (MAX_RADIUS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_item.operation),
        .i_pixel_index   (i_item.pixel_index),
        .i_channel       (i_item.channel),
        .i_pixel_byte    (i_item.pixel_byte),
        .i_out_x         (i_item.out_x),
        .i_out_y         (i_item.out_y),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (out_valid),
        .o_distance_byte (out_byte),
        .o_is_inside     (out_inside),
        .i_cmd           (cmd),
        .o_status        (status)
    );

    // Result register drives the output channel directly.
    assign o_result.valid         = out_valid;
    assign o_result.distance_byte = out_byte;
    assign o_result.is_inside     = out_inside;
endmodule
